/* rtl/core/can_cfv_pkg.sv */
// Package for the CAN command frame validator.
// Holds verdict codes, register indexes, reset values and shared types.
// No dependencies.
package can_cfv_pkg;

   localparam int unsigned IdWidth     = 11;
   localparam int unsigned LenWidth    = 4;
   localparam int unsigned CountWidth  = 9;
   localparam int unsigned MaWidth     = 25;
   localparam int unsigned VerdWidth   = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned SeqWidth    = 16;
   localparam int unsigned AmpWidth    = 15;

   // verdict codes
   localparam logic [VerdWidth-1:0] VERDICT_IGNORED      = 4'd0;
   localparam logic [VerdWidth-1:0] VERDICT_CMD_OK       = 4'd1;
   localparam logic [VerdWidth-1:0] VERDICT_HEARTBEAT    = 4'd2;
   localparam logic [VerdWidth-1:0] VERDICT_AUTH_SHORT   = 4'd3;
   localparam logic [VerdWidth-1:0] VERDICT_AUTH_SEQ     = 4'd4;
   localparam logic [VerdWidth-1:0] VERDICT_SHORT        = 4'd5;
   localparam logic [VerdWidth-1:0] VERDICT_TYPE_NONE    = 4'd6;
   localparam logic [VerdWidth-1:0] VERDICT_TYPE_RANGE   = 4'd7;
   localparam logic [VerdWidth-1:0] VERDICT_RESERVED     = 4'd8;
   localparam logic [VerdWidth-1:0] VERDICT_NEG_CHARGE   = 4'd9;
   localparam logic [VerdWidth-1:0] VERDICT_NEG_DISCHRG  = 4'd10;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_AUTH_ENABLED   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_COMMAND_ID     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HEARTBEAT_ID   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TYPE_COUNT     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_CHARGE     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_DISCHARGE  = 3'd5;

   // register reset values
   localparam logic [IdWidth-1:0]    RST_COMMAND_ID   = 11'd512;
   localparam logic [IdWidth-1:0]    RST_HEARTBEAT_ID = 11'd528;
   localparam logic [CountWidth-1:0] RST_TYPE_COUNT   = 9'd8;
   localparam logic [MaWidth-1:0]    RST_MAX_MA       = 25'd32767000;

   localparam logic [MaWidth-1:0]    MA_PER_AMP  = 25'd1000;
   localparam logic [LenWidth-1:0]   MIN_CMD_LEN = 4'd5;
   localparam logic [LenWidth-1:0]   FULL_LEN    = 4'd8;
   localparam logic [SeqWidth-1:0]   SEQ_STEP    = 16'd1;

   typedef struct packed {
      logic                  auth_enabled;
      logic [IdWidth-1:0]    command_id;
      logic [IdWidth-1:0]    heartbeat_id;
      logic [CountWidth-1:0] type_count;
      logic [MaWidth-1:0]    max_charge_ma;
      logic [MaWidth-1:0]    max_discharge_ma;
   } cfg_type;

   typedef struct packed {
      logic [IdWidth-1:0]  frame_id;
      logic [LenWidth-1:0] frame_length;
      logic [7:0]          byte0;
      logic [7:0]          byte1;
      logic [7:0]          byte2;
      logic [7:0]          byte3;
      logic [7:0]          byte4;
      logic [7:0]          byte5;
      logic [7:0]          byte6;
      logic [7:0]          byte7;
   } frame_type;

   typedef struct packed {
      logic auth_short;
      logic auth_bad;
   } seq_status_type;

   typedef struct packed {
      logic [VerdWidth-1:0] verdict;
      logic [7:0]           command_type;
      logic [MaWidth-1:0]   charge_ma;
      logic [MaWidth-1:0]   discharge_ma;
   } result_type;

endpackage

/* rtl/core/can_cfv_csr.sv */
// Configuration registers of the CAN command frame validator.
// Depends on can_cfv_pkg.
module can_cfv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [can_cfv_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [can_cfv_pkg::MaWidth-1:0]     csr_data,
   output can_cfv_pkg::cfg_type                cfg
);

   can_cfv_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            can_cfv_pkg::CSR_AUTH_ENABLED:  cfg_in.auth_enabled = csr_data[0];
            can_cfv_pkg::CSR_COMMAND_ID:
               cfg_in.command_id = csr_data[can_cfv_pkg::IdWidth-1:0];
            can_cfv_pkg::CSR_HEARTBEAT_ID:
               cfg_in.heartbeat_id = csr_data[can_cfv_pkg::IdWidth-1:0];
            can_cfv_pkg::CSR_TYPE_COUNT:
               cfg_in.type_count = csr_data[can_cfv_pkg::CountWidth-1:0];
            can_cfv_pkg::CSR_MAX_CHARGE:    cfg_in.max_charge_ma = csr_data;
            can_cfv_pkg::CSR_MAX_DISCHARGE: cfg_in.max_discharge_ma = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auth_enabled     <= 1'b0;
         cfg_ff.command_id       <= can_cfv_pkg::RST_COMMAND_ID;
         cfg_ff.heartbeat_id     <= can_cfv_pkg::RST_HEARTBEAT_ID;
         cfg_ff.type_count       <= can_cfv_pkg::RST_TYPE_COUNT;
         cfg_ff.max_charge_ma    <= can_cfv_pkg::RST_MAX_MA;
         cfg_ff.max_discharge_ma <= can_cfv_pkg::RST_MAX_MA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/can_cfv_seq.sv */
// Sequence counter tracker for authenticated frames.
// Depends on can_cfv_pkg.
module can_cfv_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        auth_enabled,
   input  logic                        advance,
   input  can_cfv_pkg::frame_type      frame,
   output can_cfv_pkg::seq_status_type status
);

   logic [can_cfv_pkg::SeqWidth-1:0] last_seq_ff, last_seq_in;
   logic                             seeded_ff, seeded_in;
   logic [can_cfv_pkg::SeqWidth-1:0] seq, next_seq;
   logic                             is_short, seq_ok;

   assign seq      = {frame.byte6, frame.byte7};
   assign next_seq = last_seq_ff + can_cfv_pkg::SEQ_STEP;
   assign is_short = frame.frame_length < can_cfv_pkg::FULL_LEN;
   assign seq_ok   = !seeded_ff || (seq == next_seq) || (seq == last_seq_ff);

   assign status.auth_short = auth_enabled && is_short;
   assign status.auth_bad   = auth_enabled && !is_short && !seq_ok;

   always_comb begin
      last_seq_in = last_seq_ff;
      seeded_in   = seeded_ff;
      if (advance && auth_enabled && !is_short && seq_ok) begin
         last_seq_in = seq;
         seeded_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         seeded_ff   <= 1'b0;
      end else begin
         last_seq_ff <= last_seq_in;
         seeded_ff   <= seeded_in;
      end
   end

endmodule

/* rtl/core/can_cfv_decode.sv */
// Command checks, limit scaling and verdict selection, combinational.
// Depends on can_cfv_pkg.
module can_cfv_decode (
   input  can_cfv_pkg::cfg_type        cfg,
   input  can_cfv_pkg::frame_type      frame,
   input  can_cfv_pkg::seq_status_type status,
   output can_cfv_pkg::result_type     result
);

   logic [can_cfv_pkg::VerdWidth-1:0] cmd_verdict;
   logic [can_cfv_pkg::AmpWidth-1:0]  chg_amps, dis_amps;
   logic [can_cfv_pkg::MaWidth-1:0]   chg_raw, dis_raw, chg_ma, dis_ma;
   logic                              is_cmd, is_hb, reserved_bad;

   assign is_cmd = frame.frame_id == cfg.command_id;
   assign is_hb  = frame.frame_id == cfg.heartbeat_id;

   assign reserved_bad = (frame.frame_length >= can_cfv_pkg::FULL_LEN) &&
                         ((frame.byte5 != 8'd0) ||
                          (!cfg.auth_enabled &&
                           ((frame.byte6 != 8'd0) || (frame.byte7 != 8'd0))));

   assign chg_amps = {frame.byte1[6:0], frame.byte2};
   assign dis_amps = {frame.byte3[6:0], frame.byte4};
   assign chg_raw  = can_cfv_pkg::MaWidth'(chg_amps) * can_cfv_pkg::MA_PER_AMP;
   assign dis_raw  = can_cfv_pkg::MaWidth'(dis_amps) * can_cfv_pkg::MA_PER_AMP;
   assign chg_ma   = (chg_raw > cfg.max_charge_ma) ? cfg.max_charge_ma : chg_raw;
   assign dis_ma   = (dis_raw > cfg.max_discharge_ma) ? cfg.max_discharge_ma : dis_raw;

   always_comb begin
      priority if (frame.frame_length < can_cfv_pkg::MIN_CMD_LEN)
         cmd_verdict = can_cfv_pkg::VERDICT_SHORT;
      else if (frame.byte0 == 8'd0)
         cmd_verdict = can_cfv_pkg::VERDICT_TYPE_NONE;
      else if ({1'b0, frame.byte0} >= cfg.type_count)
         cmd_verdict = can_cfv_pkg::VERDICT_TYPE_RANGE;
      else if (reserved_bad)
         cmd_verdict = can_cfv_pkg::VERDICT_RESERVED;
      else if (frame.byte1[7])
         cmd_verdict = can_cfv_pkg::VERDICT_NEG_CHARGE;
      else if (frame.byte3[7])
         cmd_verdict = can_cfv_pkg::VERDICT_NEG_DISCHRG;
      else
         cmd_verdict = can_cfv_pkg::VERDICT_CMD_OK;
   end

   always_comb begin
      result = '0;
      priority if (status.auth_short) begin
         result.verdict = can_cfv_pkg::VERDICT_AUTH_SHORT;
      end else if (status.auth_bad) begin
         result.verdict = can_cfv_pkg::VERDICT_AUTH_SEQ;
      end else if (is_cmd && cmd_verdict == can_cfv_pkg::VERDICT_CMD_OK) begin
         result.verdict      = can_cfv_pkg::VERDICT_CMD_OK;
         result.command_type = frame.byte0;
         result.charge_ma    = chg_ma;
         result.discharge_ma = dis_ma;
      end else if (is_hb) begin
         // a rejected command on a shared identifier reads as heartbeat
         result.verdict = can_cfv_pkg::VERDICT_HEARTBEAT;
      end else if (is_cmd) begin
         result.verdict = cmd_verdict;
      end else begin
         result.verdict = can_cfv_pkg::VERDICT_IGNORED;
      end
   end

endmodule

/* rtl/core/can_command_frame_validator.sv */
// Top level of the CAN command frame validator.
// Depends on can_cfv_pkg, can_cfv_csr, can_cfv_seq and can_cfv_decode.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   frame id, length, bytes 0..7
//   rsp_      out        rsp_valid/rsp_stall   verdict, type, limits
//   csr_      in         csr_valid/csr_ready   register index, data
//
// One item per cycle while rsp_stall is low; an item is accepted into the input
// register and then moves into the result register, where rsp_valid shows it.
// The sequence counter updates as an item moves into the result register.
// Synchronous reset clears the valid flags, the counter and the config registers.
// rsp_stall holds the result; req_stall rises only when both stages are full.
module can_command_frame_validator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [can_cfv_pkg::IdWidth-1:0]      req_frame_id,
   input  logic [can_cfv_pkg::LenWidth-1:0]     req_frame_length,
   input  logic [7:0]                           req_byte0,
   input  logic [7:0]                           req_byte1,
   input  logic [7:0]                           req_byte2,
   input  logic [7:0]                           req_byte3,
   input  logic [7:0]                           req_byte4,
   input  logic [7:0]                           req_byte5,
   input  logic [7:0]                           req_byte6,
   input  logic [7:0]                           req_byte7,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [can_cfv_pkg::VerdWidth-1:0]    rsp_verdict,
   output logic [7:0]                           rsp_command_type,
   output logic [can_cfv_pkg::MaWidth-1:0]      rsp_charge_ma,
   output logic [can_cfv_pkg::MaWidth-1:0]      rsp_discharge_ma,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [can_cfv_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [can_cfv_pkg::MaWidth-1:0]      csr_data
);

   can_cfv_pkg::cfg_type        cfg;
   can_cfv_pkg::frame_type      frame_ff, frame_in;
   can_cfv_pkg::seq_status_type status;
   can_cfv_pkg::result_type     result, result_ff;
   logic                        in_valid_ff, in_valid_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_free, advance, req_fire;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign frame_in = '{frame_id: req_frame_id, frame_length: req_frame_length,
                       byte0: req_byte0, byte1: req_byte1, byte2: req_byte2,
                       byte3: req_byte3, byte4: req_byte4, byte5: req_byte5,
                       byte6: req_byte6, byte7: req_byte7};

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   can_cfv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   can_cfv_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .auth_enabled (cfg.auth_enabled),
      .advance      (advance),
      .frame        (frame_ff),
      .status       (status)
   );

   can_cfv_decode u_decode (
      .cfg    (cfg),
      .frame  (frame_ff),
      .status (status),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff <= frame_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_verdict      = result_ff.verdict;
   assign rsp_command_type = result_ff.command_type;
   assign rsp_charge_ma    = result_ff.charge_ma;
   assign rsp_discharge_ma = result_ff.discharge_ma;

endmodule

/* rtl/core/can_cfv_checker.sv */
// Port-level checks for the CAN command frame validator, bound to the top.
// Depends on can_cfv_pkg and can_command_frame_validator.
module can_cfv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [can_cfv_pkg::VerdWidth-1:0] rsp_verdict,
   input logic [7:0]                        rsp_command_type,
   input logic [can_cfv_pkg::MaWidth-1:0]   rsp_charge_ma,
   input logic [can_cfv_pkg::MaWidth-1:0]   rsp_discharge_ma
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("stalled result changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != can_cfv_pkg::VERDICT_CMD_OK |->
      rsp_command_type == 8'd0 && rsp_charge_ma == '0 &&
      rsp_discharge_ma == '0)
      else $error("non-accepted item carries data");

   a_ok_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == can_cfv_pkg::VERDICT_CMD_OK |->
      rsp_command_type != 8'd0)
      else $error("accepted command with type zero");

   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= can_cfv_pkg::VERDICT_NEG_DISCHRG)
      else $error("verdict code out of range");

endmodule

bind can_command_frame_validator can_cfv_checker u_can_cfv_checker (.*);
